### rtl/cbst_pkg.sv
// cubic bezier tessellator package: default sizes, micro-op codes and the
// micro-op table shared by the sequencer and the multiply-accumulate unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cbst_pkg;

    localparam int COORD_BITS_DEF     = 16;
    localparam int STEP_FRAC_BITS_DEF = 10;
    localparam int STEP_RESET         = 103;

    // micro-ops per sample: six weight products, then four terms per coordinate
    localparam int UOP_WGT   = 6;
    localparam int UOP_COUNT = 18;
    localparam int UOP_BITS  = 5;

    // multiplier operand a sources
    localparam logic [2:0] A_S  = 3'd0;
    localparam logic [2:0] A_T  = 3'd1;
    localparam logic [2:0] A_SS = 3'd2;
    localparam logic [2:0] A_TT = 3'd3;
    localparam logic [2:0] A_W0 = 3'd4;
    localparam logic [2:0] A_W1 = 3'd5;
    localparam logic [2:0] A_W2 = 3'd6;
    localparam logic [2:0] A_W3 = 3'd7;

    // multiplier operand b sources
    localparam logic [1:0] B_S   = 2'd0;
    localparam logic [1:0] B_T   = 2'd1;
    localparam logic [1:0] B_CRD = 2'd2;

    // product destinations
    localparam logic [3:0] D_NONE = 4'd0;
    localparam logic [3:0] D_SS   = 4'd1;
    localparam logic [3:0] D_TT   = 4'd2;
    localparam logic [3:0] D_W0   = 4'd3;
    localparam logic [3:0] D_W1   = 4'd4;
    localparam logic [3:0] D_W2   = 4'd5;
    localparam logic [3:0] D_W3   = 4'd6;
    localparam logic [3:0] D_ACC0 = 4'd7;
    localparam logic [3:0] D_ACC  = 4'd8;
    localparam logic [3:0] D_ACCN = 4'd9;

    typedef struct packed {
        logic       vld;
        logic [2:0] a_src;
        logic [1:0] b_src;
        logic [3:0] dst;
        logic [1:0] term;
        logic [1:0] coord;
    } t_mac_req;

    function automatic t_mac_req uop_decode(input logic [UOP_BITS-1:0] idx);
        t_mac_req r;
        logic [UOP_BITS-1:0] m;
        r = '0;
        r.dst = D_NONE;
        m = idx - UOP_BITS'(UOP_WGT);
        case (idx)
            UOP_BITS'(0): begin
                r.a_src = A_S;  r.b_src = B_S; r.dst = D_SS;
            end
            UOP_BITS'(1): begin
                r.a_src = A_T;  r.b_src = B_T; r.dst = D_TT;
            end
            UOP_BITS'(2): begin
                r.a_src = A_SS; r.b_src = B_S; r.dst = D_W0;
            end
            UOP_BITS'(3): begin
                r.a_src = A_SS; r.b_src = B_T; r.dst = D_W1;
            end
            UOP_BITS'(4): begin
                r.a_src = A_TT; r.b_src = B_S; r.dst = D_W2;
            end
            UOP_BITS'(5): begin
                r.a_src = A_TT; r.b_src = B_T; r.dst = D_W3;
            end
            default: begin
                r.b_src = B_CRD;
                r.coord = m[3:2];
                r.term  = m[1:0];
                case (m[1:0])
                    2'd0: begin r.a_src = A_W0; r.dst = D_ACC0; end
                    2'd1: begin r.a_src = A_W1; r.dst = D_ACC;  end
                    2'd2: begin r.a_src = A_W2; r.dst = D_ACC;  end
                    default: begin r.a_src = A_W3; r.dst = D_ACCN; end
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/cbst_ctrl_pts.sv
// control point arithmetic: 4*q +- neighbor difference, saturated to signed Q16.2
// depends on cbst_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbst_ctrl_pts import cbst_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0]   i_prev  [3],
    input  logic signed [COORD_BITS-1:0]   i_earl  [3],
    input  logic signed [COORD_BITS-1:0]   i_pt    [3],
    output logic signed [COORD_BITS+1:0]   o_first [3],
    output logic signed [COORD_BITS+1:0]   o_in    [3],
    output logic signed [COORD_BITS+1:0]   o_new   [3],
    output logic signed [COORD_BITS+1:0]   o_end   [3]
);

    localparam int CTRL_BITS = COORD_BITS + 2;
    localparam int EXT       = COORD_BITS + 4;
    localparam logic signed [EXT-1:0] C_MAX = (EXT'(1) <<< (CTRL_BITS - 1)) - EXT'(1);
    localparam logic signed [EXT-1:0] C_MIN = -C_MAX - EXT'(1);

    function automatic logic signed [CTRL_BITS-1:0] sat_ctrl(input logic signed [EXT-1:0] v);
        logic signed [CTRL_BITS-1:0] r;
        if (v > C_MAX) begin
            r = C_MAX[CTRL_BITS-1:0];
        end else if (v < C_MIN) begin
            r = C_MIN[CTRL_BITS-1:0];
        end else begin
            r = v[CTRL_BITS-1:0];
        end
        return r;
    endfunction

    logic signed [EXT-1:0] w_q4   [3];
    logic signed [EXT-1:0] w_p4   [3];
    logic signed [EXT-1:0] w_d_pp [3];
    logic signed [EXT-1:0] w_d_pe [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_q4[j]    = EXT'(i_prev[j]) <<< 2;
            w_p4[j]    = EXT'(i_pt[j]) <<< 2;
            w_d_pp[j]  = EXT'(i_pt[j]) - EXT'(i_prev[j]);
            w_d_pe[j]  = EXT'(i_pt[j]) - EXT'(i_earl[j]);
            o_first[j] = sat_ctrl(w_q4[j] + w_d_pp[j]);
            o_in[j]    = sat_ctrl(w_q4[j] - w_d_pe[j]);
            o_new[j]   = sat_ctrl(w_q4[j] + w_d_pe[j]);
            o_end[j]   = sat_ctrl(w_p4[j] - w_d_pp[j]);
        end
    end

endmodule

`default_nettype wire

### rtl/cbst_mac.sv
// shared multiplier with product register, bernstein weight registers,
// accumulator and round/saturate of the three coordinate sums
// depends on cbst_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbst_mac import cbst_pkg::*; #(
    parameter int COORD_BITS     = COORD_BITS_DEF,
    parameter int STEP_FRAC_BITS = STEP_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mac_req                      i_req,
    input  logic [STEP_FRAC_BITS-1:0]     i_t,
    input  logic signed [COORD_BITS+1:0]  i_coord,
    output logic signed [COORD_BITS-1:0]  o_res [3]
);

    localparam int F         = STEP_FRAC_BITS;
    localparam int CTRL_BITS = COORD_BITS + 2;
    localparam int SHIFT     = 3 * F + 2;
    localparam int WGT_BITS  = 3 * F + 2;
    localparam int B_BITS    = (CTRL_BITS > F + 2) ? CTRL_BITS : F + 2;
    localparam int PROD_BITS = WGT_BITS + 1 + B_BITS;
    localparam int ACC_BITS  = CTRL_BITS + SHIFT;

    localparam logic [F:0] ONE_T = (F + 1)'(1) << F;
    localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (SHIFT - 1);
    localparam logic signed [CTRL_BITS-1:0] O_MAX =
        (CTRL_BITS'(1) <<< (COORD_BITS - 1)) - CTRL_BITS'(1);
    localparam logic signed [CTRL_BITS-1:0] O_MIN = -O_MAX - CTRL_BITS'(1);

    function automatic logic signed [COORD_BITS-1:0] sat_out(
        input logic signed [CTRL_BITS-1:0] v
    );
        logic signed [COORD_BITS-1:0] r;
        if (v > O_MAX) begin
            r = O_MAX[COORD_BITS-1:0];
        end else if (v < O_MIN) begin
            r = O_MIN[COORD_BITS-1:0];
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    logic [F:0]                     w_s;
    logic [WGT_BITS-1:0]            w_a;
    logic signed [B_BITS-1:0]       w_b;
    logic signed [PROD_BITS-1:0]    w_prod;

    logic [WGT_BITS-1:0]            r_ss, r_tt, r_w0, r_w1, r_w2, r_w3;
    logic signed [PROD_BITS-1:0]    r_prod;
    logic signed [ACC_BITS-1:0]     r_acc;
    logic signed [COORD_BITS-1:0]   r_res [3];
    t_mac_req                       r_req;

    logic [WGT_BITS-1:0]            w_pw, w_pw3;
    logic signed [ACC_BITS-1:0]     w_pa, w_sum;
    logic signed [CTRL_BITS-1:0]    w_rnd;

    assign w_s = ONE_T - (F + 1)'(i_t);

    always_comb begin
        case (i_req.a_src)
            A_S:     w_a = WGT_BITS'(w_s);
            A_T:     w_a = WGT_BITS'(i_t);
            A_SS:    w_a = r_ss;
            A_TT:    w_a = r_tt;
            A_W0:    w_a = r_w0;
            A_W1:    w_a = r_w1;
            A_W2:    w_a = r_w2;
            default: w_a = r_w3;
        endcase
        case (i_req.b_src)
            B_S:     w_b = B_BITS'(w_s);
            B_T:     w_b = B_BITS'(i_t);
            B_CRD:   w_b = B_BITS'(i_coord);
            default: w_b = '0;
        endcase
    end

    assign w_prod = $signed({1'b0, w_a}) * w_b;

    assign w_pw  = r_prod[WGT_BITS-1:0];
    assign w_pw3 = w_pw + (w_pw << 1);
    assign w_pa  = r_prod[ACC_BITS-1:0];
    assign w_sum = r_acc + w_pa;
    assign w_rnd = w_sum[ACC_BITS-1:SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req <= '0;
        end else begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (r_req.vld) begin
            case (r_req.dst)
                D_SS:   r_ss  <= w_pw;
                D_TT:   r_tt  <= w_pw;
                D_W0:   r_w0  <= w_pw;
                D_W1:   r_w1  <= w_pw3;
                D_W2:   r_w2  <= w_pw3;
                D_W3:   r_w3  <= w_pw;
                D_ACC0: r_acc <= HALF + w_pa;
                D_ACC:  r_acc <= w_sum;
                D_ACCN: begin
                    for (int j = 0; j < 3; j++) begin
                        if (r_req.coord == 2'(j)) begin
                            r_res[j] <= sat_out(w_rnd);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

### rtl/cubic_bezier_spline_tessellator.sv
// streaming cubic bezier tessellator top: point history, segment sequencer and
// output register; uses cbst_ctrl_pts and cbst_mac
// each sample: 18 micro-ops issued to the one shared multiplier, then drain, then emit,
//   which waits while the output register is full; a new point is taken only once the
//   previous one is done; up to 31 samples per segment, plus an end point copy after the
//   final segment of a curve; reset: synchronous active low, step to 103
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_spline_tessellator import cbst_pkg::*; #(
    parameter int COORD_BITS     = COORD_BITS_DEF,
    parameter int STEP_FRAC_BITS = STEP_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [STEP_FRAC_BITS:0]       i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_BITS-1:0]  i_point_x,
    input  logic signed [COORD_BITS-1:0]  i_point_y,
    input  logic signed [COORD_BITS-1:0]  i_point_z,
    input  logic                          i_is_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_BITS-1:0]  o_out_x,
    output logic signed [COORD_BITS-1:0]  o_out_y,
    output logic signed [COORD_BITS-1:0]  o_out_z,
    output logic                          o_run_end,
    output logic                          o_curve_end
);

    localparam int F         = STEP_FRAC_BITS;
    localparam int CTRL_BITS = COORD_BITS + 2;
    localparam logic [F:0] MIN_STEP = (F + 1)'((2 ** F + 30) / 31);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_SAMP  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_COPY  = 3'd5;

    logic [2:0]                    r_state;
    logic [F:0]                    r_step;
    logic [1:0]                    r_seen;
    logic                          r_last;
    logic                          r_seg_b;
    logic                          r_second;
    logic [UOP_BITS-1:0]           r_uop;
    logic [F-1:0]                  r_t;
    logic signed [COORD_BITS-1:0]  r_pt   [3];
    logic signed [COORD_BITS-1:0]  r_prev [3];
    logic signed [COORD_BITS-1:0]  r_earl [3];
    logic signed [CTRL_BITS-1:0]   r_octl [3];
    logic signed [CTRL_BITS-1:0]   r_seg  [4][3];
    logic signed [CTRL_BITS-1:0]   r_nxt  [4][3];

    logic                          r_ov;
    logic signed [COORD_BITS-1:0]  r_ox, r_oy, r_oz;
    logic                          r_orun, r_ocend;

    logic signed [CTRL_BITS-1:0]   w_first [3];
    logic signed [CTRL_BITS-1:0]   w_in    [3];
    logic signed [CTRL_BITS-1:0]   w_new   [3];
    logic signed [CTRL_BITS-1:0]   w_end   [3];
    logic signed [COORD_BITS-1:0]  w_res   [3];

    logic [F:0]                    w_inc;
    logic [F+1:0]                  n_t;
    logic                          w_seg_done;
    logic                          w_slot;
    logic                          w_load;
    logic                          w_accept;
    t_mac_req                      w_req;
    logic signed [CTRL_BITS-1:0]   w_coord;

    cbst_ctrl_pts #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .i_prev  (r_prev),
        .i_earl  (r_earl),
        .i_pt    (r_pt),
        .o_first (w_first),
        .o_in    (w_in),
        .o_new   (w_new),
        .o_end   (w_end)
    );

    always_comb begin
        w_req     = uop_decode(r_uop);
        w_req.vld = (r_state == ST_SAMP);
    end

    assign w_coord = r_seg[w_req.term][w_req.coord];

    cbst_mac #(
        .COORD_BITS     (COORD_BITS),
        .STEP_FRAC_BITS (STEP_FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_t     (r_t),
        .i_coord (w_coord),
        .o_res   (w_res)
    );

    assign w_inc      = (r_step < MIN_STEP) ? MIN_STEP : r_step;
    assign n_t        = (F + 2)'(r_t) + (F + 2)'(w_inc);
    assign w_seg_done = (n_t[F+1:F] != 2'd0);
    assign w_slot     = !r_ov || i_out_ready;
    assign w_load     = w_slot && (r_state == ST_EMIT || r_state == ST_COPY);
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= (F + 1)'(STEP_RESET);
            r_seen   <= 2'd0;
            r_seg_b  <= 1'b0;
            r_second <= 1'b0;
            r_uop    <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_data;
            end
            r_ov <= w_load || (r_ov && !i_out_ready);
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    if (r_seen < 2'd2) begin
                        r_seen  <= r_last ? 2'd0 : r_seen + 2'd1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_seen   <= r_last ? 2'd0 : 2'd3;
                        r_state  <= ST_SAMP;
                        r_uop    <= '0;
                        r_seg_b  <= 1'b0;
                        r_second <= r_last;
                    end
                end
                ST_SAMP: begin
                    if (r_uop == UOP_BITS'(UOP_COUNT - 1)) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_uop <= r_uop + UOP_BITS'(1);
                    end
                end
                ST_DRAIN: begin
                    r_uop   <= '0;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (w_slot) begin
                        if (!w_seg_done) begin
                            r_state <= ST_SAMP;
                        end else if (!r_seg_b && r_second) begin
                            r_seg_b <= 1'b1;
                            r_state <= ST_SAMP;
                        end else if (r_seg_b) begin
                            r_state <= ST_COPY;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_COPY: begin
                    if (w_slot) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pt[0] <= i_point_x;
            r_pt[1] <= i_point_y;
            r_pt[2] <= i_point_z;
            r_last  <= i_is_last;
        end
        if (r_state == ST_PREP) begin
            case (r_seen)
                2'd0: begin
                    r_prev <= r_pt;
                end
                2'd1: begin
                    r_octl <= w_first;
                    r_earl <= r_prev;
                    r_prev <= r_pt;
                end
                default: begin
                    r_t <= '0;
                    for (int j = 0; j < 3; j++) begin
                        r_seg[0][j] <= {r_earl[j], 2'b00};
                        r_seg[1][j] <= r_octl[j];
                        r_seg[2][j] <= w_in[j];
                        r_seg[3][j] <= {r_prev[j], 2'b00};
                        r_nxt[0][j] <= {r_prev[j], 2'b00};
                        r_nxt[1][j] <= w_new[j];
                        r_nxt[2][j] <= w_end[j];
                        r_nxt[3][j] <= {r_pt[j], 2'b00};
                    end
                    if (!r_last) begin
                        r_earl <= r_prev;
                        r_prev <= r_pt;
                        r_octl <= w_new;
                    end
                end
            endcase
        end
        if (r_state == ST_EMIT && w_slot) begin
            r_ox    <= w_res[0];
            r_oy    <= w_res[1];
            r_oz    <= w_res[2];
            r_orun  <= w_seg_done && !r_second;
            r_ocend <= 1'b0;
            if (!w_seg_done) begin
                r_t <= n_t[F-1:0];
            end else if (!r_seg_b && r_second) begin
                r_seg <= r_nxt;
                r_t   <= '0;
            end
        end
        if (r_state == ST_COPY && w_slot) begin
            r_ox    <= r_pt[0];
            r_oy    <= r_pt[1];
            r_oz    <= r_pt[2];
            r_orun  <= 1'b1;
            r_ocend <= 1'b1;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_out_z     = r_oz;
    assign o_run_end   = r_orun;
    assign o_curve_end = r_ocend;

    a_uop_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SAMP) |-> (r_uop < UOP_BITS'(UOP_COUNT)))
        else $error("micro-op index past end of sample sequence");

    a_curve_end_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_curve_end) |-> o_run_end)
        else $error("curve end point without run end");

    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_PREP))
        else $error("input transaction not followed by prep");

    a_seg_b_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg_b |-> r_second)
        else $error("final segment running without last point");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_ov && !i_out_ready) |=> (r_state == ST_EMIT))
        else $error("sample dropped while output register full");

endmodule

`default_nettype wire

### verif/cubic_bezier_spline_tessellator_test.sv
// self-checking testbench for the cubic bezier spline tessellator: directed and random
// point streams against a behavioral bezier sampler, with random idling on both sides
// depends on cbst_pkg and cubic_bezier_spline_tessellator
`timescale 1ns / 1ps

module cubic_bezier_spline_tessellator_test import cbst_pkg::*;;

    localparam int     CB          = COORD_BITS_DEF;
    localparam int     FB          = STEP_FRAC_BITS_DEF;
    localparam longint ONE_T       = longint'(1) << FB;
    localparam longint MIN_STEP    = (ONE_T + 30) / 31;
    localparam int     SHIFT       = 3 * FB + 2;
    localparam int     IDLE_CYCLES = 64;
    localparam int     STALL_LEN   = 400;
    localparam longint COORD_MAX   = (longint'(1) << (CB - 1)) - 1;
    localparam longint COORD_MIN   = -COORD_MAX - 1;

    typedef longint vec3_t [3];

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
        logic                 run_end;
        logic                 curve_end;
    } curve_sample_t;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [FB:0]          cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic signed [CB-1:0] pt_x       = '0;
    logic signed [CB-1:0] pt_y       = '0;
    logic signed [CB-1:0] pt_z       = '0;
    logic                 pt_last    = 1'b0;
    logic                 out_ready  = 1'b0;
    wire                  in_ready;
    wire                  out_valid;
    wire signed [CB-1:0]  out_x;
    wire signed [CB-1:0]  out_y;
    wire signed [CB-1:0]  out_z;
    wire                  run_end;
    wire                  curve_end;

    // sampler state
    vec3_t         prev_pt;
    vec3_t         early_pt;
    vec3_t         out_ctrl;
    int            pts_seen;
    longint        step_reg;
    curve_sample_t pending_samples[$];
    curve_sample_t head_sample;
    int            errors    = 0;
    int            stall_req = 0;
    bit            no_idle   = 1'b0;

    always #5 i_clk = ~i_clk;

    cubic_bezier_spline_tessellator #(
        .COORD_BITS     (CB),
        .STEP_FRAC_BITS (FB)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_point_x   (pt_x),
        .i_point_y   (pt_y),
        .i_point_z   (pt_z),
        .i_is_last   (pt_last),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_x     (out_x),
        .o_out_y     (out_y),
        .o_out_z     (out_z),
        .o_run_end   (run_end),
        .o_curve_end (curve_end)
    );

    function automatic longint clamp(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint bezier_coord(input longint p0, input longint c1,
                                            input longint c2, input longint p3,
                                            input longint w0, input longint w1,
                                            input longint w2, input longint w3);
        longint acc;
        acc = p0 * 4 * w0 + c1 * w1 + c2 * w2 + p3 * 4 * w3 + (longint'(1) << (SHIFT - 1));
        return clamp(acc >>> SHIFT, CB);
    endfunction

    function automatic void reset_curve();
        prev_pt  = '{0, 0, 0};
        early_pt = '{0, 0, 0};
        out_ctrl = '{0, 0, 0};
        pts_seen = 0;
    endfunction

    task automatic emit_segment_samples(input vec3_t a, input vec3_t c1, input vec3_t c2,
                                        input vec3_t b);
        longint        inc;
        longint        t;
        longint        s;
        longint        w0;
        longint        w1;
        longint        w2;
        longint        w3;
        curve_sample_t smp;
        inc = step_reg < MIN_STEP ? MIN_STEP : step_reg;
        for (t = 0; t < ONE_T; t += inc) begin
            s  = ONE_T - t;
            w0 = s * s * s;
            w1 = 3 * s * s * t;
            w2 = 3 * s * t * t;
            w3 = t * t * t;
            smp.x = CB'(bezier_coord(a[0], c1[0], c2[0], b[0], w0, w1, w2, w3));
            smp.y = CB'(bezier_coord(a[1], c1[1], c2[1], b[1], w0, w1, w2, w3));
            smp.z = CB'(bezier_coord(a[2], c1[2], c2[2], b[2], w0, w1, w2, w3));
            smp.run_end   = 1'b0;
            smp.curve_end = 1'b0;
            pending_samples.insert(pending_samples.size(), smp);
        end
    endtask

    task automatic tessellate_point(input logic signed [CB-1:0] px,
                                    input logic signed [CB-1:0] py,
                                    input logic signed [CB-1:0] pz, input logic last);
        vec3_t         p;
        vec3_t         in_ctrl;
        vec3_t         new_out;
        vec3_t         end_ctrl;
        longint        diff;
        int            start_count;
        int            j;
        curve_sample_t smp;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        start_count = pending_samples.size();
        if (pts_seen == 0) begin
            prev_pt  = p;
            pts_seen = 1;
        end else if (pts_seen == 1) begin
            for (j = 0; j < 3; j++)
                out_ctrl[j] = clamp(prev_pt[j] * 4 + (p[j] - prev_pt[j]), CB + 2);
            early_pt = prev_pt;
            prev_pt  = p;
            pts_seen = 2;
        end else begin
            for (j = 0; j < 3; j++) begin
                diff       = p[j] - early_pt[j];
                in_ctrl[j] = clamp(prev_pt[j] * 4 - diff, CB + 2);
                new_out[j] = clamp(prev_pt[j] * 4 + diff, CB + 2);
            end
            emit_segment_samples(early_pt, out_ctrl, in_ctrl, prev_pt);
            if (last) begin
                for (j = 0; j < 3; j++)
                    end_ctrl[j] = clamp(p[j] * 4 - (p[j] - prev_pt[j]), CB + 2);
                emit_segment_samples(prev_pt, new_out, end_ctrl, p);
                smp.x         = px;
                smp.y         = py;
                smp.z         = pz;
                smp.run_end   = 1'b0;
                smp.curve_end = 1'b1;
                pending_samples.insert(pending_samples.size(), smp);
            end else begin
                early_pt = prev_pt;
                prev_pt  = p;
                out_ctrl = new_out;
                pts_seen = 3;
            end
        end
        if (last)
            reset_curve();
        if (pending_samples.size() > start_count) begin
            smp = pending_samples.pop_back();
            smp.run_end = 1'b1;
            pending_samples.insert(pending_samples.size(), smp);
        end
    endtask

    task automatic send_point(input logic signed [CB-1:0] px, input logic signed [CB-1:0] py,
                              input logic signed [CB-1:0] pz, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        pt_x     <= px;
        pt_y     <= py;
        pt_z     <= pz;
        pt_last  <= last;
        do @(posedge i_clk); while (!in_ready);
        tessellate_point(px, py, pz, last);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_step(input logic [FB:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        step_reg = value;
    endtask

    function automatic logic signed [CB-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return CB'(COORD_MAX);
            1:       return CB'(COORD_MIN);
            2, 3:    return CB'(int'($urandom_range(0, 1023)) - 512);
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic logic [FB:0] rand_step();
        case ($urandom_range(0, 5))
            0:       return (FB + 1)'($urandom_range(0, (1 << (FB + 1)) - 1));
            1:       return (FB + 1)'(MIN_STEP);
            default: return (FB + 1)'($urandom_range(int'(MIN_STEP), int'(ONE_T)));
        endcase
    endfunction

    task automatic send_curve(input int len);
        int i;
        for (i = 0; i < len; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // extreme coordinates at the reset step, control points saturate
    task automatic test_extreme_points();
        send_point(CB'(COORD_MAX), CB'(COORD_MIN), '0, 1'b0);
        send_point(CB'(COORD_MIN), CB'(COORD_MAX), CB'(1), 1'b0);
        send_point(CB'(COORD_MAX), CB'(COORD_MAX), CB'(COORD_MIN), 1'b0);
        send_point(CB'(COORD_MIN), CB'(COORD_MIN), CB'(COORD_MAX), 1'b1);
    endtask

    // curves of one, two and three points
    task automatic test_short_curves();
        send_point(CB'(256), CB'(-256), CB'(512), 1'b1);
        send_point(CB'(100), CB'(200), CB'(-300), 1'b0);
        send_point(CB'(-100), CB'(0), CB'(300), 1'b1);
        send_point('0, '0, '0, 1'b0);
        send_point(CB'(1024), CB'(-1024), CB'(1), 1'b0);
        send_point(CB'(-1), CB'(2048), CB'(-2048), 1'b1);
    endtask

    // zero, below the minimum, the minimum, one sample, all ones
    task automatic test_step_limits();
        int step_limits [5];
        int k;
        step_limits = '{0, int'(MIN_STEP) - 1, int'(MIN_STEP), int'(ONE_T),
                        (1 << (FB + 1)) - 1};
        for (k = 0; k < 5; k++) begin
            set_step((FB + 1)'(step_limits[k]));
            send_curve(3);
        end
    endtask

    task automatic test_random_curves();
        int sent;
        int len;
        sent = 0;
        while (sent < 110) begin
            if ($urandom_range(0, 3) == 0)
                set_step(rand_step());
            no_idle = ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            send_curve(len);
            sent += len;
        end
        no_idle = 1'b0;
    endtask

    // receiver holds off while points keep coming, input must stall
    task automatic test_output_stall();
        set_step((FB + 1)'(103));
        stall_req = STALL_LEN;
        no_idle   = 1'b1;
        send_curve(8);
        no_idle   = 1'b0;
    endtask

    // sender pauses mid curve until every sample is out
    task automatic test_sender_pause();
        int i;
        for (i = 0; i < 3; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
        wait_idle();
        for (i = 0; i < 3; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), i == 2);
    endtask

    // receiver
    initial begin
        int gap;
        int n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (stall_req > 0) begin
                n = stall_req;
                stall_req = 0;
                out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!(out_valid && out_ready));
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected transaction, expected none actual x=%0d y=%0d z=%0d",
                         $time, out_x, out_y, out_z);
                errors++;
            end else begin
                head_sample = pending_samples.pop_front();
                check_field("out_x", head_sample.x, out_x);
                check_field("out_y", head_sample.y, out_y);
                check_field("out_z", head_sample.z, out_z);
                check_field("run_end", head_sample.run_end, run_end);
                check_field("curve_end", head_sample.curve_end, curve_end);
            end
        end
    end

    initial begin
        reset_curve();
        step_reg = STEP_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extreme_points();
        test_short_curves();
        test_step_limits();
        test_output_stall();
        test_sender_pause();
        test_random_curves();
        wait_idle();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
